FILE: rtl/ssr_pkg.sv
// shared types, constants and glyph table for the seven-segment rasterizer
`default_nettype none

package ssr_pkg;

    // sizing
    localparam int MAX_DIGITS = 16;
    localparam int MAX_SCALE  = 15;
    localparam int DIGIT_AW   = $clog2(MAX_DIGITS);
    localparam int SCALE_W    = 4;
    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 4;
    localparam int VALUE_W    = 4;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 9;
    localparam int CODE_W     = 2;
    localparam int DIV_W      = $clog2(MAX_SCALE + 4);
    localparam int PROD_W     = COUNT_W + DIV_W;
    localparam int CNT_W      = $clog2(COL_W);
    localparam int SEG_W      = 7;

    // stream and config port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd1;

    // beat kinds carried on the input tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // cell codes
    localparam logic [CODE_W-1:0] CELL_SPACE = 2'd0;
    localparam logic [CODE_W-1:0] CELL_DASH  = 2'd1;
    localparam logic [CODE_W-1:0] CELL_BAR   = 2'd2;

    // segment bit positions
    localparam int SEG_TOP = 0;
    localparam int SEG_UR  = 1;
    localparam int SEG_LR  = 2;
    localparam int SEG_BOT = 3;
    localparam int SEG_LL  = 4;
    localparam int SEG_UL  = 5;
    localparam int SEG_MID = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FETCH,
        ST_DECODE,
        ST_FINISH
    } t_state;

    // lit segments per digit code, codes above nine are blank
    function automatic logic [SEG_W-1:0] glyph_segs(input logic [VALUE_W-1:0] code);
        logic [SEG_W-1:0] segs;
        case (code)
            4'd0:    segs = 7'h3F;
            4'd1:    segs = 7'h06;
            4'd2:    segs = 7'h5B;
            4'd3:    segs = 7'h4F;
            4'd4:    segs = 7'h66;
            4'd5:    segs = 7'h6D;
            4'd6:    segs = 7'h7D;
            4'd7:    segs = 7'h07;
            4'd8:    segs = 7'h7F;
            4'd9:    segs = 7'h6F;
            default: segs = 7'h00;
        endcase
        return segs;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ssr_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none

module ssr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/scaled_seven_segment_rasterizer_top.sv
// top level of the scaled seven-segment rasterizer
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: index, value, row, column; tuser: mode
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: cell code; tuser: out of range
//  cfg      | in  | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// one beat in flight at a time; the next beat is taken as soon as the
// previous result sits in the output register, even if it is stalled there
// a write beat: store write on accept, then the result
// a read beat inside the raster: range check, a 9-step restoring divider
// that splits the column into digit and offset, one store read, decode and
// the result; a read outside the raster goes from the check to the result
// sync active-low reset clears control and sets scale and count to 1; the store has no reset
// output stalls only hold the finished result, the core waits in its last state
`default_nettype none

module scaled_seven_segment_rasterizer_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave side
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [3:0] digit_index, [7:4] digit_value, [13:8] row, [22:14] column, [23] zero
    input  wire logic [ssr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] mode
    input  wire logic                               s_axis_tuser,
    // master side
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [1:0] cell_code, [7:2] zero
    output logic      [ssr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [0] out_of_range
    output logic                                    m_axis_tuser,
    // configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic [ssr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ssr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import ssr_pkg::*;

    // field split of the input beat
    logic [INDEX_W-1:0] s_index;
    logic [VALUE_W-1:0] s_value;
    logic [ROW_W-1:0]   s_row;
    logic [COL_W-1:0]   s_col;

    assign s_index = s_axis_tdata[3:0];
    assign s_value = s_axis_tdata[7:4];
    assign s_row   = s_axis_tdata[13:8];
    assign s_col   = s_axis_tdata[22:14];

    // control and config registers
    t_state r_state, n_state;
    logic [SCALE_W-1:0] r_scale;
    logic [COUNT_W-1:0] r_count;

    // item registers
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_quo, n_quo;     // dividend in, quotient out
    logic [DIV_W-1:0]  r_rem, n_rem;     // running remainder = column offset
    logic [DIV_W-1:0]  r_div, n_div;     // digit pitch, scale + 3
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CODE_W-1:0] r_res_code, n_res_code;
    logic              r_res_oor, n_res_oor;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_oor;

    // handshake and store controls
    logic              in_beat;
    logic              out_load;
    logic              ram_we;
    logic              ram_re;
    logic [VALUE_W-1:0] ram_rdata;

    // geometry from the current config
    logic [COUNT_W-1:0] count_sat;
    logic [DIV_W-1:0]   pitch;
    logic [DIV_W-1:0]   cell_w;
    logic [ROW_W-1:0]   row_h;
    logic [ROW_W-1:0]   row_mid;
    logic [PROD_W-1:0]  raster_w1;       // raster width plus one
    logic               chk_oor;

    // divider step
    logic [DIV_W:0]     trial;
    logic               trial_ge;

    // decode
    logic [SEG_W-1:0]   segs;
    logic               off_left, off_right, off_gap, digit_high;
    logic               seg_need;
    logic [CODE_W-1:0]  dec_code;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // count saturates at the store depth; the 4-bit scale never exceeds its max
    assign count_sat = (r_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : r_count;
    assign pitch     = DIV_W'(r_scale) + DIV_W'(3);
    assign cell_w    = DIV_W'(r_scale) + DIV_W'(2);
    assign row_h     = {1'b0, r_scale, 1'b0} + ROW_W'(3);
    assign row_mid   = ROW_W'(r_scale) + ROW_W'(2);
    assign raster_w1 = PROD_W'(count_sat) * PROD_W'(pitch);

    // column beyond the raster means column >= count * pitch
    assign chk_oor = (r_row == '0) || (r_row > row_h) || (r_quo == '0)
                   || (PROD_W'(r_quo) >= raster_w1);

    // restoring divider, one quotient bit per cycle
    assign trial    = {r_rem, r_quo[COL_W-1]};
    assign trial_ge = (trial >= {1'b0, r_div});

    // cell decode from the stored digit and the column offset
    assign segs       = glyph_segs(ram_rdata);
    assign off_left   = (r_rem == '0);
    assign off_right  = (r_rem == (cell_w - DIV_W'(1)));
    assign off_gap    = (r_rem == cell_w);
    assign digit_high = (r_quo >= COL_W'(MAX_DIGITS));

    always_comb begin
        if (r_row == ROW_W'(1)) begin
            seg_need = segs[SEG_TOP];
        end else if (r_row == row_mid) begin
            seg_need = segs[SEG_MID];
        end else begin
            seg_need = segs[SEG_BOT];
        end
    end

    always_comb begin
        dec_code = CELL_SPACE;
        if (off_gap || digit_high) begin
            dec_code = CELL_SPACE;
        end else if (r_row == ROW_W'(1) || r_row == row_mid || r_row == row_h) begin
            if (!off_left && !off_right && seg_need) begin
                dec_code = CELL_DASH;
            end
        end else if (r_row < row_mid) begin
            if ((off_left && segs[SEG_UL]) || (off_right && segs[SEG_UR])) begin
                dec_code = CELL_BAR;
            end
        end else begin
            if ((off_left && segs[SEG_LL]) || (off_right && segs[SEG_LR])) begin
                dec_code = CELL_BAR;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser == MODE_READ) ? ST_CHECK : ST_FINISH;
                end
            end
            ST_CHECK: begin
                n_state = chk_oor ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (r_cnt == CNT_W'(COL_W - 1)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_FETCH: begin
                ram_re = 1'b1;
            end
            ST_FINISH: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // a write beat goes straight into the store
    assign ram_we = in_beat && (s_axis_tuser == MODE_WRITE) && (32'(s_index) < MAX_DIGITS);

    // datapath next values
    always_comb begin
        n_row      = r_row;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_div      = r_div;
        n_cnt      = r_cnt;
        n_res_code = r_res_code;
        n_res_oor  = r_res_oor;
        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_row      = s_row;
                    n_quo      = s_col;
                    n_res_code = CELL_SPACE;
                    n_res_oor  = 1'b0;
                end
            end
            ST_CHECK: begin
                n_res_code = CELL_SPACE;
                n_res_oor  = chk_oor;
                n_div      = pitch;
                n_quo      = r_quo - COL_W'(1);
                n_rem      = '0;
                n_cnt      = '0;
            end
            ST_DIVIDE: begin
                n_rem = trial_ge ? DIV_W'(trial - {1'b0, r_div}) : DIV_W'(trial);
                n_quo = {r_quo[COL_W-2:0], trial_ge};
                n_cnt = r_cnt + CNT_W'(1);
            end
            ST_DECODE: begin
                n_res_code = dec_code;
            end
            default: begin
                n_row = r_row;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !m_axis_tready) || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scale     <= SCALE_W'(1);
            r_count     <= COUNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_index == REG_SCALE) begin
                r_scale <= i_cfg_data[SCALE_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_DIGIT_COUNT) begin
                r_count <= i_cfg_data[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_cnt      <= n_cnt;
        r_res_code <= n_res_code;
        r_res_oor  <= n_res_oor;
        if (out_load) begin
            r_out_code <= r_res_code;
            r_out_oor  <= r_res_oor;
        end
    end

    // digit store
    ssr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_index[DIGIT_AW-1:0]),
        .i_wdata (s_value),
        .i_re    (ram_re),
        .i_raddr (r_quo[DIGIT_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - CODE_W){1'b0}}, r_out_code};
    assign m_axis_tuser  = r_out_oor;

    // only one beat in flight
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !s_axis_tready)
        else $error("beat accepted while another is in flight");

    // divider leaves a remainder below the pitch
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_rem < r_div))
        else $error("column offset not below digit pitch");

    // an out-of-range result is always a space
    a_oor_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[CODE_W-1:0] == CELL_SPACE))
        else $error("out-of-range result with a glyph");

    // no unused cell code reaches the output
    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CODE_W-1:0] == CELL_SPACE
                        || m_axis_tdata[CODE_W-1:0] == CELL_DASH
                        || m_axis_tdata[CODE_W-1:0] == CELL_BAR))
        else $error("illegal cell code");

endmodule

`default_nettype wire
